// ===== hw/rtl/sob_pkg.sv =====
// Shared widths and fixed-point constants of the Syamlal-O'Brien drag pipeline.
`default_nettype none
package sob_pkg;
    localparam int FRAC_W = 17;   // Q1.16 phase fractions
    localparam int RE_W   = 24;   // Q16.8 Reynolds number
    localparam int OUT_W  = 40;   // Q32.8 drag product
    localparam int EXP_W  = 5;    // integer part of log2
    localparam int LOG_W  = 24;   // fraction bits of log2
    localparam int POW_W  = 31;   // Q.30 power result
    localparam int P_W    = 19;   // Q.16 exponents

    localparam logic [FRAC_W-1:0] ONE_Q16    = 17'd65536;
    localparam logic [FRAC_W-1:0] THRESH_085 = 17'd55705;
    localparam logic [FRAC_W-1:0] RESID_RST  = 17'd1;
    localparam logic [P_W-1:0]    P_414      = 19'd271319;
    localparam logic [P_W-1:0]    P_128      = 19'd83886;
    localparam logic [P_W-1:0]    P_265      = 19'd173670;
    localparam logic [15:0]       K_08       = 16'd52429;
    localparam logic [21:0]       K_006      = 22'd4026532;
    localparam logic [15:0]       K_063      = 16'd41288;
    localparam logic [18:0]       K_48       = 19'd314573;
endpackage
`default_nettype wire

// ===== hw/rtl/syamlal_obrien_drag_coefficient.sv =====
// Top level of the Syamlal-O'Brien drag product pipeline.
//
//  channel   direction  ports                          word contents (low bit up)
//  s         in         i_s_tvalid/o_s_tready/tdata    dispersed, continuous, reynolds
//  m         out        o_m_tvalid/i_m_tready/tdata    drag_product; tuser = saturated
//  cfg       in         i_cfg_valid/o_cfg_ready/data   residual_fraction
//
// One word per cycle is accepted and delivered while the output is not stalled; the longest
// part of the pipeline is the 24 chained 31-stage square-root rounds of the exp2 in the power units.
// Reset clears all valid bits and sets residual_fraction to one LSB.
// A stall at the output is absorbed by a skid register; the pipeline freezes only while
// that register is occupied, so nothing is dropped or repeated.
`default_nettype none
module syamlal_obrien_drag_coefficient
    import sob_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [63:0]       i_s_tdata,   // dispersed[16:0], continuous[33:17], reynolds[57:34]
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_W-1:0]  o_m_tdata,   // drag_product[39:0]
    output logic              o_m_tuser,   // saturated
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [FRAC_W-1:0] i_cfg_data   // residual_fraction
);
    localparam int PHI_PAY = RE_W + FRAC_W;

    logic               en;
    logic [FRAC_W-1:0]  r_residual;

    // Input stage
    logic [FRAC_W-1:0]  in_disp, in_cont, one_minus, al, alpha2;
    logic [RE_W-1:0]    in_re;
    logic               r_s0_valid;
    logic [FRAC_W-1:0]  r_s0_alpha, r_s0_phi;
    logic [RE_W-1:0]    r_s0_re;
    logic               r_s0_sel;

    // Log and power units
    logic               lg_valid, lg_zero;
    logic [EXP_W-1:0]   lg_e;
    logic [LOG_W-1:0]   lg_frac;
    logic [PHI_PAY:0]   lg_pay;
    logic               ea_valid, eb_valid, eb_sel;
    logic [POW_W-1:0]   ea_pow, eb_pow;
    logic [PHI_PAY-1:0] ea_pay;

    // Velocity ratio
    logic [46:0]        x1_bprod;
    logic [45:0]        x1_cprod;
    logic               r_x1_valid;
    logic [18:0]        r_x1_a, r_x1_b;
    logic [29:0]        r_x1_c;
    logic [PHI_PAY-1:0] r_x1_pay;
    logic               r_x2_valid, r_x2_negd;
    logic [29:0]        r_x2_ad;
    logic [48:0]        r_x2_cb;
    logic [PHI_PAY-1:0] r_x2_pay;
    logic               r_x3_valid, r_x3_negd;
    logic [29:0]        r_x3_ad;
    logic [59:0]        r_x3_sq;
    logic [48:0]        r_x3_cb;
    logic [PHI_PAY-1:0] r_x3_pay;
    logic               r_x4_valid;
    logic [61:0]        r_x4_rad;
    logic [PHI_PAY+79:0] r_x4_pay;  // phi+re, cb, negd, ad
    logic               sr_valid;
    logic [30:0]        sr_root;
    logic [PHI_PAY+79:0] sr_pay;
    logic               r_v1_valid;
    logic [31:0]        r_v1_vrpos, r_v1_den;
    logic [49:0]        r_v1_num;
    logic [PHI_PAY:0]   r_v1_pay;   // phi+re, negd
    logic               d1_valid;
    logic [49:0]        d1_quot;
    logic [PHI_PAY+32:0] d1_pay;
    logic               r_v2_valid;
    logic [31:0]        r_v2_vr;
    logic [RE_W-1:0]    r_v2_re;
    logic [FRAC_W-1:0]  r_v2_phi;

    // Single-particle term and quotient
    logic               sq1_valid;
    logic [25:0]        sq1_root;
    logic [48:0]        sq1_pay;    // phi, vr
    logic               sq2_valid;
    logic [24:0]        sq2_root;
    logic [74:0]        sq2_pay;    // phi, vr, sqrt(Re)
    logic               r_m1_valid;
    logic [41:0]        r_m1_p1;
    logic [43:0]        r_m1_p2;
    logic [31:0]        r_m1_vr;
    logic [FRAC_W-1:0]  r_m1_phi;
    logic [44:0]        m2_sum;
    logic               r_m2_valid;
    logic [28:0]        r_m2_s;
    logic [31:0]        r_m2_vr;
    logic [FRAC_W-1:0]  r_m2_phi;
    logic               r_m3_valid;
    logic [57:0]        r_m3_ss;
    logic [63:0]        r_m3_den;
    logic [FRAC_W-1:0]  r_m3_phi;
    logic [62:0]        m4_prod;
    logic               r_m4_valid;
    logic [66:0]        r_m4_num;
    logic [63:0]        r_m4_den;
    logic               d2_valid;
    logic [66:0]        d2_quot;
    logic               d2_zero;
    logic               fin_sat;
    logic [OUT_W-1:0]   fin_data;

    // Output register and skid
    logic               r_o_valid;
    logic [OUT_W-1:0]   r_o_data;
    logic               r_o_sat;
    logic               r_skid_valid;
    logic [OUT_W-1:0]   r_skid_data;
    logic               r_skid_sat;

    assign en          = !r_skid_valid;
    assign o_s_tready  = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_residual <= RESID_RST;
        end else if (i_cfg_valid) begin
            r_residual <= i_cfg_data;
        end
    end

    // Carrier fraction: 1 - dispersed, floored at the residual, limited to one.
    assign in_disp   = i_s_tdata[16:0];
    assign in_cont   = i_s_tdata[33:17];
    assign in_re     = i_s_tdata[57:34];
    assign one_minus = (in_disp >= ONE_Q16) ? '0 : ONE_Q16 - in_disp;
    assign al        = (r_residual > one_minus) ? r_residual : one_minus;
    assign alpha2    = (al > ONE_Q16) ? ONE_Q16 : al;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_x1_valid <= 1'b0;
            r_x2_valid <= 1'b0;
            r_x3_valid <= 1'b0;
            r_x4_valid <= 1'b0;
            r_v1_valid <= 1'b0;
            r_v2_valid <= 1'b0;
            r_m1_valid <= 1'b0;
            r_m2_valid <= 1'b0;
            r_m3_valid <= 1'b0;
            r_m4_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_s_tvalid;
            r_x1_valid <= ea_valid & eb_valid;
            r_x2_valid <= r_x1_valid;
            r_x3_valid <= r_x2_valid;
            r_x4_valid <= r_x3_valid;
            r_v1_valid <= sr_valid;
            r_v2_valid <= d1_valid;
            r_m1_valid <= sq2_valid;
            r_m2_valid <= r_m1_valid;
            r_m3_valid <= r_m2_valid;
            r_m4_valid <= r_m3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_alpha <= alpha2;
            r_s0_phi   <= (in_cont > r_residual) ? in_cont : r_residual;
            r_s0_re    <= in_re;
            r_s0_sel   <= alpha2 <= THRESH_085;
        end
    end

    sob_log #(
        .PW (PHI_PAY + 1)
    ) u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s0_valid),
        .i_x     (r_s0_alpha),
        .i_pay   ({r_s0_sel, r_s0_re, r_s0_phi}),
        .o_valid (lg_valid),
        .o_e     (lg_e),
        .o_frac  (lg_frac),
        .o_zero  (lg_zero),
        .o_pay   (lg_pay)
    );

    sob_exp #(
        .PW (PHI_PAY)
    ) u_exp_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (lg_valid),
        .i_e     (lg_e),
        .i_frac  (lg_frac),
        .i_zero  (lg_zero),
        .i_p     (P_414),
        .i_pay   (lg_pay[PHI_PAY-1:0]),
        .o_valid (ea_valid),
        .o_pow   (ea_pow),
        .o_pay   (ea_pay)
    );

    sob_exp #(
        .PW (1)
    ) u_exp_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (lg_valid),
        .i_e     (lg_e),
        .i_frac  (lg_frac),
        .i_zero  (lg_zero),
        .i_p     (lg_pay[PHI_PAY] ? P_128 : P_265),
        .i_pay   (lg_pay[PHI_PAY]),
        .o_valid (eb_valid),
        .o_pow   (eb_pow),
        .o_pay   (eb_sel)
    );

    assign x1_bprod = 47'(K_08) * 47'(eb_pow);
    assign x1_cprod = 46'(ea_pay[PHI_PAY-1:FRAC_W]) * 46'(K_006);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x1_a    <= ea_pow[30:12];
            r_x1_b    <= eb_sel ? x1_bprod[46:28] : eb_pow[30:12];
            r_x1_c    <= x1_cprod[45:16];
            r_x1_pay  <= ea_pay;
            r_x2_negd <= {11'b0, r_x1_a} < r_x1_c;
            r_x2_ad   <= ({11'b0, r_x1_a} < r_x1_c) ? r_x1_c - {11'b0, r_x1_a}
                                                    : {11'b0, r_x1_a} - r_x1_c;
            r_x2_cb   <= 49'(r_x1_c) * 49'(r_x1_b);
            r_x2_pay  <= r_x1_pay;
            r_x3_sq   <= 60'(r_x2_ad) * 60'(r_x2_ad);
            r_x3_ad   <= r_x2_ad;
            r_x3_negd <= r_x2_negd;
            r_x3_cb   <= r_x2_cb;
            r_x3_pay  <= r_x2_pay;
            r_x4_rad  <= 62'(r_x3_sq) + 62'({r_x3_cb, 2'b00});
            r_x4_pay  <= {r_x3_ad, r_x3_negd, r_x3_cb, r_x3_pay};
        end
    end

    sob_sqrt #(
        .W  (62),
        .PW (PHI_PAY + 80)
    ) u_sqrt_s (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_x4_valid),
        .i_radicand (r_x4_rad),
        .i_pay      (r_x4_pay),
        .o_valid    (sr_valid),
        .o_root     (sr_root),
        .o_pay      (sr_pay)
    );

    // Vr = (|d| + S) / 2 for d >= 0, else 2cB / (S + |d|).
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v1_vrpos <= 32'((33'(sr_pay[PHI_PAY+79:PHI_PAY+50]) + 33'(sr_root)) >> 1);
            r_v1_den   <= 32'(sr_pay[PHI_PAY+79:PHI_PAY+50]) + 32'(sr_root);
            r_v1_num   <= {sr_pay[PHI_PAY+48:PHI_PAY], 1'b0};
            r_v1_pay   <= {sr_pay[PHI_PAY+49], sr_pay[PHI_PAY-1:0]};
        end
    end

    sob_div #(
        .NW (50),
        .DW (32),
        .PW (PHI_PAY + 33)
    ) u_div_vr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v1_valid),
        .i_num   (r_v1_num),
        .i_den   (r_v1_den),
        .i_pay   ({r_v1_vrpos, r_v1_pay}),
        .o_valid (d1_valid),
        .o_quot  (d1_quot),
        .o_pay   (d1_pay)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v2_vr  <= d1_pay[PHI_PAY] ? d1_quot[31:0] : d1_pay[PHI_PAY+32:PHI_PAY+1];
            r_v2_re  <= d1_pay[PHI_PAY-1:FRAC_W];
            r_v2_phi <= d1_pay[FRAC_W-1:0];
        end
    end

    sob_sqrt #(
        .W  (52),
        .PW (49)
    ) u_sqrt_re (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_v2_valid),
        .i_radicand ({r_v2_re, 28'b0}),
        .i_pay      ({r_v2_vr, r_v2_phi}),
        .o_valid    (sq1_valid),
        .o_root     (sq1_root),
        .o_pay      (sq1_pay)
    );

    sob_sqrt #(
        .W  (50),
        .PW (75)
    ) u_sqrt_vr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (sq1_valid),
        .i_radicand ({sq1_pay[48:17], 18'b0}),
        .i_pay      ({sq1_root, sq1_pay}),
        .o_valid    (sq2_valid),
        .o_root     (sq2_root),
        .o_pay      (sq2_pay)
    );

    assign m2_sum  = 45'(r_m1_p1) + 45'(r_m1_p2);
    assign m4_prod = 63'(r_m3_ss[57:12]) * 63'(r_m3_phi);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_p1  <= 42'(K_063) * 42'(sq2_pay[74:49]);
            r_m1_p2  <= 44'(K_48) * 44'(sq2_root);
            r_m1_vr  <= sq2_pay[48:17];
            r_m1_phi <= sq2_pay[16:0];
            r_m2_s   <= m2_sum[44:16];
            r_m2_vr  <= r_m1_vr;
            r_m2_phi <= r_m1_phi;
            r_m3_ss  <= 58'(r_m2_s) * 58'(r_m2_s);
            r_m3_den <= 64'(r_m2_vr) * 64'(r_m2_vr);
            r_m3_phi <= r_m2_phi;
            r_m4_num <= {m4_prod, 4'b0000};
            r_m4_den <= r_m3_den;
        end
    end

    sob_div #(
        .NW (67),
        .DW (64),
        .PW (1)
    ) u_div_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_m4_valid),
        .i_num   (r_m4_num),
        .i_den   (r_m4_den),
        .i_pay   (r_m4_den == '0),
        .o_valid (d2_valid),
        .o_quot  (d2_quot),
        .o_pay   (d2_zero)
    );

    // A zero velocity ratio or a quotient past 40 bits clips to all ones.
    assign fin_sat  = d2_zero || (|d2_quot[66:OUT_W]);
    assign fin_data = fin_sat ? '1 : d2_quot[OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid    <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_o_valid || i_m_tready) begin
            r_o_valid    <= r_skid_valid || (d2_valid && en);
            r_skid_valid <= 1'b0;
        end else if (d2_valid && en) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_o_valid || i_m_tready) begin
            r_o_data <= r_skid_valid ? r_skid_data : fin_data;
            r_o_sat  <= r_skid_valid ? r_skid_sat : fin_sat;
        end else if (d2_valid && en) begin
            r_skid_data <= fin_data;
            r_skid_sat  <= fin_sat;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_sat;
endmodule
`default_nettype wire

// ===== hw/rtl/sob_sqrt.sv =====
// Pipelined floor square root, one root bit per stage.
`default_nettype none
module sob_sqrt #(
    parameter int W  = 62,
    parameter int PW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [W-1:0]    i_radicand,
    input  logic [PW-1:0]   i_pay,
    output logic            o_valid,
    output logic [W/2-1:0]  o_root,
    output logic [PW-1:0]   o_pay
);
    localparam int N = W / 2;

    logic          r_valid [1:N];
    logic [W-1:0]  r_rem   [1:N];
    logic [N-1:0]  r_root  [1:N];
    logic [PW-1:0] r_pay   [1:N];

    genvar k;
    for (k = 1; k <= N; k++) begin : g_stage
        localparam int B = N - k;
        logic          pv;
        logic [W-1:0]  prem;
        logic [N-1:0]  proot;
        logic [PW-1:0] ppay;
        logic [W+1:0]  term;
        logic [W+1:0]  diff;
        logic          take;

        if (k == 1) begin : g_first
            assign pv    = i_valid;
            assign prem  = i_radicand;
            assign proot = '0;
            assign ppay  = i_pay;
        end else begin : g_next
            assign pv    = r_valid[k-1];
            assign prem  = r_rem[k-1];
            assign proot = r_root[k-1];
            assign ppay  = r_pay[k-1];
        end

        // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
        assign term = ({{(W+2-N){1'b0}}, proot} << (B + 1)) | ((W+2)'(1) << (2 * B));
        assign take = {2'b00, prem} >= term;
        assign diff = {2'b00, prem} - term;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= take ? diff[W-1:0] : prem;
                r_root[k] <= take ? (proot | (N'(1) << B)) : proot;
                r_pay[k]  <= ppay;
            end
        end
    end

    assign o_valid = r_valid[N];
    assign o_root  = r_root[N];
    assign o_pay   = r_pay[N];
endmodule
`default_nettype wire

// ===== hw/rtl/sob_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module sob_div #(
    parameter int NW = 50,
    parameter int DW = 32,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [NW-1:0] o_quot,
    output logic [PW-1:0] o_pay
);
    logic          r_valid [1:NW];
    logic [DW-1:0] r_rem   [1:NW];
    logic [NW-1:0] r_num   [1:NW];
    logic [DW-1:0] r_den   [1:NW];
    logic [NW-1:0] r_quot  [1:NW];
    logic [PW-1:0] r_pay   [1:NW];

    genvar k;
    for (k = 1; k <= NW; k++) begin : g_stage
        localparam int B = NW - k;
        logic          pv;
        logic [DW-1:0] prem;
        logic [NW-1:0] pnum;
        logic [DW-1:0] pden;
        logic [NW-1:0] pquot;
        logic [PW-1:0] ppay;
        logic [DW:0]   rem2;
        logic [DW:0]   diff;
        logic          take;

        if (k == 1) begin : g_first
            assign pv    = i_valid;
            assign prem  = '0;
            assign pnum  = i_num;
            assign pden  = i_den;
            assign pquot = '0;
            assign ppay  = i_pay;
        end else begin : g_next
            assign pv    = r_valid[k-1];
            assign prem  = r_rem[k-1];
            assign pnum  = r_num[k-1];
            assign pden  = r_den[k-1];
            assign pquot = r_quot[k-1];
            assign ppay  = r_pay[k-1];
        end

        assign rem2 = {prem, pnum[B]};
        assign take = rem2 >= {1'b0, pden};
        assign diff = rem2 - {1'b0, pden};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= take ? diff[DW-1:0] : rem2[DW-1:0];
                r_num[k]  <= pnum;
                r_den[k]  <= pden;
                r_quot[k] <= take ? (pquot | (NW'(1) << B)) : pquot;
                r_pay[k]  <= ppay;
            end
        end
    end

    assign o_valid = r_valid[NW];
    assign o_quot  = r_quot[NW];
    assign o_pay   = r_pay[NW];
endmodule
`default_nettype wire

// ===== hw/rtl/sob_log.sv =====
// Pipelined log2 of a Q1.16 fraction by repeated squaring, one fraction bit per stage.
`default_nettype none
module sob_log
    import sob_pkg::*;
#(
    parameter int PW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [FRAC_W-1:0] i_x,
    input  logic [PW-1:0]     i_pay,
    output logic              o_valid,
    output logic [EXP_W-1:0]  o_e,
    output logic [LOG_W-1:0]  o_frac,
    output logic              o_zero,
    output logic [PW-1:0]     o_pay
);
    logic [EXP_W-1:0] pre_e;

    logic             r_pre_valid;
    logic [EXP_W-1:0] r_pre_e;
    logic [POW_W-1:0] r_pre_m;
    logic             r_pre_zero;
    logic [PW-1:0]    r_pre_pay;

    logic             r_valid [1:LOG_W];
    logic [EXP_W-1:0] r_e     [1:LOG_W];
    logic [POW_W-1:0] r_m     [1:LOG_W];
    logic [LOG_W-1:0] r_frac  [1:LOG_W];
    logic             r_zero  [1:LOG_W];
    logic [PW-1:0]    r_pay   [1:LOG_W];

    always_comb begin
        pre_e = '0;
        for (int i = 0; i < FRAC_W; i++) begin
            if (i_x[i]) begin
                pre_e = EXP_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid <= 1'b0;
        end else if (i_en) begin
            r_pre_valid <= i_valid;
        end
    end

    // Normalize so that the leading one sits at bit 30 (Q1.30 mantissa in [1, 2)).
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pre_e    <= pre_e;
            r_pre_m    <= {{(POW_W-FRAC_W){1'b0}}, i_x} << (EXP_W'(30) - pre_e);
            r_pre_zero <= i_x == '0;
            r_pre_pay  <= i_pay;
        end
    end

    genvar j;
    for (j = 0; j < LOG_W; j++) begin : g_sq
        logic             pv;
        logic [EXP_W-1:0] pe;
        logic [POW_W-1:0] pm;
        logic [LOG_W-1:0] pfrac;
        logic             pzero;
        logic [PW-1:0]    ppay;
        logic [2*POW_W-1:0] prod;
        logic [POW_W:0]   m2;

        if (j == 0) begin : g_first
            assign pv    = r_pre_valid;
            assign pe    = r_pre_e;
            assign pm    = r_pre_m;
            assign pfrac = '0;
            assign pzero = r_pre_zero;
            assign ppay  = r_pre_pay;
        end else begin : g_next
            assign pv    = r_valid[j];
            assign pe    = r_e[j];
            assign pm    = r_m[j];
            assign pfrac = r_frac[j];
            assign pzero = r_zero[j];
            assign ppay  = r_pay[j];
        end

        assign prod = (2*POW_W)'(pm) * (2*POW_W)'(pm);
        assign m2   = prod[2*POW_W-1:30];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[j+1] <= pv;
            end
        end

        // A square at or above two yields the next log bit and is halved back.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[j+1]    <= m2[POW_W] ? m2[POW_W:1] : m2[POW_W-1:0];
                r_frac[j+1] <= m2[POW_W] ? (pfrac | (LOG_W'(1) << (LOG_W - 1 - j))) : pfrac;
                r_e[j+1]    <= pe;
                r_zero[j+1] <= pzero;
                r_pay[j+1]  <= ppay;
            end
        end
    end

    assign o_valid = r_valid[LOG_W];
    assign o_e     = r_e[LOG_W];
    assign o_frac  = r_frac[LOG_W];
    assign o_zero  = r_zero[LOG_W];
    assign o_pay   = r_pay[LOG_W];
endmodule
`default_nettype wire

// ===== hw/rtl/sob_exp.sv =====
// Power unit back end: scales the log by an exponent and runs exp2 as square-root rounds.
`default_nettype none
module sob_exp
    import sob_pkg::*;
#(
    parameter int PW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [EXP_W-1:0]  i_e,
    input  logic [LOG_W-1:0]  i_frac,
    input  logic              i_zero,
    input  logic [P_W-1:0]    i_p,
    input  logic [PW-1:0]     i_pay,
    output logic              o_valid,
    output logic [POW_W-1:0]  o_pow,
    output logic [PW-1:0]     o_pay
);
    // Round payload from the lowest bit: caller payload, zero flag, k, f.
    localparam int PPW = PW + 33;

    logic [28:0]      nl;
    logic [47:0]      tprod;

    logic             r_t_valid;
    logic [31:0]      r_t;
    logic             r_t_zero;
    logic [PW-1:0]    r_t_pay;

    logic             w_v [0:LOG_W];
    logic [POW_W-1:0] w_r [0:LOG_W];
    logic [PPW-1:0]   w_p [0:LOG_W];

    logic [7:0]       fin_k;
    logic             fin_zero;

    logic             r_valid;
    logic [POW_W-1:0] r_pow;
    logic [PW-1:0]    r_pay;

    assign nl    = {EXP_W'(16) - i_e, {LOG_W{1'b0}}} - {{EXP_W{1'b0}}, i_frac};
    assign tprod = 48'(nl) * 48'(i_p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
        end else if (i_en) begin
            r_t_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t      <= tprod[47:16];
            r_t_zero <= i_zero;
            r_t_pay  <= i_pay;
        end
    end

    assign w_v[0] = r_t_valid;
    assign w_r[0] = POW_W'(1) << 30;
    assign w_p[0] = {r_t[23:0], r_t[31:24], r_t_zero, r_t_pay};

    // Each round halves when its fraction bit is set, then takes a Q.30 square root.
    genvar j;
    for (j = 0; j < LOG_W; j++) begin : g_round
        logic [POW_W-1:0] rin;
        assign rin = w_p[j][PW+9+j] ? (w_r[j] >> 1) : w_r[j];

        sob_sqrt #(
            .W  (2 * POW_W),
            .PW (PPW)
        ) u_sqrt (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (i_en),
            .i_valid    (w_v[j]),
            .i_radicand ({1'b0, rin, 30'b0}),
            .i_pay      (w_p[j]),
            .o_valid    (w_v[j+1]),
            .o_root     (w_r[j+1]),
            .o_pay      (w_p[j+1])
        );
    end

    assign fin_k    = w_p[LOG_W][PW+8:PW+1];
    assign fin_zero = w_p[LOG_W][PW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= w_v[LOG_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pow <= (fin_zero || fin_k >= 8'd31) ? '0 : (w_r[LOG_W] >> fin_k[4:0]);
            r_pay <= w_p[LOG_W][PW-1:0];
        end
    end

    assign o_valid = r_valid;
    assign o_pow   = r_pow;
    assign o_pay   = r_pay;
endmodule
`default_nettype wire

// ===== hw/rtl/sob_chk.sv =====
// Port-level checker for the drag pipeline, bound to the top level.
`default_nettype none
module sob_chk
    import sob_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_s_tready,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [OUT_W-1:0]  o_m_tdata,
    input logic              o_m_tuser
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output word valid right after reset");

    a_sat_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '1)
        else $error("saturated word is not all ones");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled while no output word is waiting");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled output word changed");
endmodule

bind syamlal_obrien_drag_coefficient sob_chk u_sob_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire
